### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the IR transmitter modules.
// Every use assumes a clock named clk_i and an active-low reset named rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define IRTX_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define IRTX_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### hdl/irtx_pkg.sv
// ----------------------------------------------------------------------------
// irtx_pkg
// Types, codes and constants of the pulse-width IR frame transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package irtx_pkg;

  localparam int FRAME_BITS     = 6;
  localparam int TICK_WIDTH_DEF = 16;
  localparam int ADDR_W         = 2;
  localparam int CMD_W          = 4;
  localparam int UNIT_W         = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int UNITS_W        = 3;
  localparam int BITS_W         = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS     = 1'b1;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 16'd40;

  // Segment lengths in timing units
  localparam logic [UNITS_W-1:0] START_MARK_UNITS  = 3'd4;
  localparam logic [UNITS_W-1:0] START_SPACE_UNITS = 3'd2;
  localparam logic [UNITS_W-1:0] ONE_MARK_UNITS    = 3'd2;
  localparam logic [UNITS_W-1:0] ZERO_MARK_UNITS   = 3'd1;
  localparam logic [UNITS_W-1:0] BIT_SPACE_UNITS   = 3'd1;

  localparam logic [BITS_W-1:0] FRAME_BITS_INIT = BITS_W'(FRAME_BITS);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_START_MARK  = 3'd1,
    PH_START_SPACE = 3'd2,
    PH_BIT_MARK    = 3'd3,
    PH_BIT_SPACE   = 3'd4
  } phase_e;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_SEND = 1'b1
  } mode_e;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } result_t;

endpackage

`default_nettype wire

### hdl/irtx_core.sv
// ----------------------------------------------------------------------------
// irtx_core
// Frame state, configuration registers and the single-pass next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module irtx_core #(
  parameter int TICK_WIDTH = irtx_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [irtx_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [irtx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            accept_i,
  input  wire logic                            mode_i,
  input  wire logic [irtx_pkg::CMD_W-1:0]      command_i,
  output irtx_pkg::result_t                    result_o
);
  import irtx_pkg::*;

  logic [ADDR_W-1:0]     dev_addr_q;
  logic [UNIT_W-1:0]     unit_ticks_q;

  logic [FRAME_BITS-1:0] shift_q, shift_d, shift_nxt;
  logic [BITS_W-1:0]     bits_q, bits_d, bits_dec;
  phase_e                phase_q, phase_d;
  logic [UNITS_W-1:0]    units_q, units_d, units_dec;
  logic [TICK_WIDTH-1:0] tick_q, tick_d, tick_inc, unit_cmp;
  logic                  carrier_q, carrier_d;
  logic                  busy, is_mark;
  result_t               res;

  // unit_ticks of zero wraps to a full 2^TICK_WIDTH-tick unit
  assign unit_cmp  = TICK_WIDTH'(unit_ticks_q);
  assign tick_inc  = tick_q + TICK_WIDTH'(1);
  assign units_dec = units_q - UNITS_W'(1);
  assign bits_dec  = bits_q - BITS_W'(1);
  assign shift_nxt = {shift_q[FRAME_BITS-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= '0;
      unit_ticks_q <= UNIT_TICKS_RST;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_DEVICE_ADDRESS) begin
        dev_addr_q <= cfg_wdata_i[ADDR_W-1:0];
      end
      if (cfg_addr_i == REG_UNIT_TICKS) begin
        unit_ticks_q <= cfg_wdata_i[UNIT_W-1:0];
      end
    end
  end

  always_comb begin
    shift_d   = shift_q;
    bits_d    = bits_q;
    phase_d   = phase_q;
    units_d   = units_q;
    tick_d    = tick_q;
    carrier_d = carrier_q;
    res       = '0;
    busy      = (phase_q != PH_IDLE);
    is_mark   = (phase_q == PH_START_MARK) || (phase_q == PH_BIT_MARK);

    if (mode_i == MODE_SEND) begin
      if (busy) begin
        res.rejected = 1'b1;
        res.ir_level = carrier_q;
      end else begin
        shift_d   = {dev_addr_q, command_i};
        bits_d    = FRAME_BITS_INIT;
        phase_d   = PH_START_MARK;
        units_d   = START_MARK_UNITS;
        tick_d    = '0;
        carrier_d = 1'b0;
      end
    end else if (busy) begin
      carrier_d    = is_mark ? ~carrier_q : 1'b0;
      res.ir_level = carrier_d;
      if (tick_inc == unit_cmp) begin
        tick_d  = '0;
        units_d = units_dec;
        if (units_dec == '0) begin
          unique case (phase_q)
            PH_START_MARK: begin
              phase_d   = PH_START_SPACE;
              units_d   = START_SPACE_UNITS;
              carrier_d = 1'b0;
            end
            PH_START_SPACE: begin
              phase_d   = PH_BIT_MARK;
              units_d   = shift_q[FRAME_BITS-1] ? ONE_MARK_UNITS : ZERO_MARK_UNITS;
              carrier_d = 1'b0;
            end
            PH_BIT_MARK: begin
              phase_d   = PH_BIT_SPACE;
              units_d   = BIT_SPACE_UNITS;
              carrier_d = 1'b0;
            end
            default: begin
              // end of a bit space: next bit or end of frame
              shift_d   = shift_nxt;
              bits_d    = bits_dec;
              carrier_d = 1'b0;
              if (bits_dec == '0) begin
                phase_d        = PH_IDLE;
                res.frame_done = 1'b1;
              end else begin
                phase_d = PH_BIT_MARK;
                units_d = shift_nxt[FRAME_BITS-1] ? ONE_MARK_UNITS : ZERO_MARK_UNITS;
              end
            end
          endcase
        end
      end else begin
        tick_d = tick_inc;
      end
    end

    res.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= '0;
      bits_q    <= '0;
      phase_q   <= PH_IDLE;
      units_q   <= '0;
      tick_q    <= '0;
      carrier_q <= 1'b0;
    end else if (accept_i) begin
      shift_q   <= shift_d;
      bits_q    <= bits_d;
      phase_q   <= phase_d;
      units_q   <= units_d;
      tick_q    <= tick_d;
      carrier_q <= carrier_d;
    end
  end

  assign result_o = res;

  `IRTX_ASSERT(a_reject_only_busy,
    (accept_i && res.rejected) |-> (mode_i == MODE_SEND && phase_q != PH_IDLE),
    "reject outside a busy send")
  `IRTX_ASSERT(a_done_from_space,
    (accept_i && res.frame_done) |-> (phase_q == PH_BIT_SPACE && bits_q == BITS_W'(1)),
    "frame end not from the last bit space")
  `IRTX_ASSERT(a_done_goes_idle,
    (accept_i && res.frame_done) |=> (phase_q == PH_IDLE),
    "still busy after frame end")
  `IRTX_NEVER(a_idle_carrier_low,
    (phase_q == PH_IDLE) && carrier_q,
    "carrier high while idle")

endmodule

`default_nettype wire

### hdl/irtx_skid.sv
// ----------------------------------------------------------------------------
// irtx_skid
// Two-entry result buffer; registered upstream ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module irtx_skid (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire irtx_pkg::result_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output irtx_pkg::result_t      out_data_o
);
  import irtx_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    accept;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !main_valid_q) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !main_valid_q) begin
      main_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (accept) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  `IRTX_NEVER(a_skid_implies_main,
    skid_valid_q && !main_valid_q,
    "skid entry without main entry")
  `IRTX_ASSERT(a_skid_drains,
    (skid_valid_q && out_ready_i) |=> (main_valid_q && !skid_valid_q),
    "skid entry not moved on drain")
  `IRTX_ASSERT(a_skid_fill_on_stall,
    $rose(skid_valid_q) |-> $past(main_valid_q && !out_ready_i),
    "skid filled without a stall")

endmodule

`default_nettype wire

### hdl/ir_pulse_width_frame_transmitter.sv
// Each result is registered in the output buffer (main or skid entry) before it appears on the master side.
// Throughput: one item per clock cycle while s_axis_tready is high; next-state logic is a single pass per item.
// A two-entry output buffer keeps the slave side open while one result waits.
// Reset (rst_ni low, asynchronous): idle, counters cleared, address 0, unit length 40.
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_transmitter
// Pulse-width IR remote transmitter: start bit and six frame bits per send.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_frame_transmitter #(
  parameter int TICK_WIDTH = irtx_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [irtx_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [irtx_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [3:0] command
  input  wire logic                            s_axis_tuser,  // [0] mode
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata,  // [0] ir_level [1] busy_res [2] rejected
  output logic                                 m_axis_tlast   // frame_done
);
  import irtx_pkg::*;

  result_t core_res, out_res;
  logic    in_accept;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  irtx_core #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (in_accept),
    .mode_i     (s_axis_tuser),
    .command_i  (s_axis_tdata[CMD_W-1:0]),
    .result_o   (core_res)
  );

  irtx_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (core_res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.rejected, out_res.busy_res, out_res.ir_level};
  assign m_axis_tlast = out_res.frame_done;

endmodule

`default_nettype wire
